// File: design/mm_pkg.sv
// Shared types and constants for the matrix multiplier.
package mm_pkg;

    localparam int CFG_W       = 4;    // width of one dimension register
    localparam int SIZE_W      = 8;    // rows*cols of two CFG_W values
    localparam int CMD_W       = 2;
    localparam int PRODUCT_W   = 40;   // signed Q40.0 sum, saturated
    localparam int IDX_W       = 3;
    localparam int M_DATA_W    = 48;   // product, row, column, zero pad
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef enum logic [1:0] {
        CFG_LEFT_ROWS  = 2'd0,
        CFG_LEFT_COLS  = 2'd1,
        CFG_RIGHT_ROWS = 2'd2,
        CFG_RIGHT_COLS = 2'd3
    } t_cfg_idx;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_LEFT  = 2'd0,
        CMD_LOAD_RIGHT = 2'd1,
        CMD_COMPUTE    = 2'd2
    } t_cmd;

    // Classified operations handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_WR_LEFT  = 2'd0,
        OP_WR_RIGHT = 2'd1,
        OP_COMPUTE  = 2'd2,
        OP_MISMATCH = 2'd3
    } t_op;

    // Effective (clamped) matrix dimensions.
    typedef struct packed {
        logic [CFG_W-1:0] left_rows;
        logic [CFG_W-1:0] left_cols;
        logic [CFG_W-1:0] right_rows;
        logic [CFG_W-1:0] right_cols;
    } t_dims;

    typedef struct packed {
        logic signed [PRODUCT_W-1:0] product;
        logic [IDX_W-1:0]            row;
        logic [IDX_W-1:0]            col;
        logic                        last;
        logic                        error;
    } t_result;

endpackage

// File: design/matrix_multiply_top.sv
// Top level of the matrix multiplier: configuration registers and stream ports.
//
// Usage:
//   Config channel: write left_rows, left_cols, right_rows, right_cols (index 0..3)
//   while the block is idle; values clamp to 1..MAX_DIM. o_cfg_ready is always high.
//   Slave stream: tuser is the command (load left, load right, compute), tdata the
//   signed element. Loads fill each store row-major; loads past rows*cols are dropped.
//   Master stream: tdata = product, row, column; tlast marks the final result of a
//   compute; tuser flags a dimension mismatch, sent as a single result.
// Timing:
//   Requests pass a 4-entry queue; the back end takes a load only while it is idle.
//   A compute issues one multiply-accumulate per cycle, unless the output stalls it,
//   from one read port per store; each term passes the read and product registers,
//   and a result enters the output register when the last term of its sum is added.
//   When the receiver stalls, the output register holds, and a finished sum waiting for it
//   freezes the pipeline; the queue keeps taking requests until full, then s_axis_tready drops.
// Reset clears load pointers and store valid bits at once (unwritten elements read
// as zero) and sets all dimensions to 8; no clearing pass is needed.
module matrix_multiply_top #(
    parameter int MAX_DIM      = 8,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [1:0]                           i_cfg_index,
    input  logic [mm_pkg::CFG_W-1:0]             i_cfg_data,
    // request stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((ELEMENT_BITS+7)/8)*8-1:0]    s_axis_tdata,  // element, zero pad
    input  logic [mm_pkg::CMD_W-1:0]             s_axis_tuser,  // command
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [mm_pkg::M_DATA_W-1:0]          m_axis_tdata,  // product, row, column, pad
    output logic                                 m_axis_tlast,
    output logic [0:0]                           m_axis_tuser   // dimension error
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int Q_W    = 2 + ADDR_W + ELEMENT_BITS;
    localparam int PAD_W  = mm_pkg::M_DATA_W - mm_pkg::PRODUCT_W - 2 * mm_pkg::IDX_W;

    logic [mm_pkg::CFG_W-1:0] r_left_rows, r_left_cols, r_right_rows, r_right_cols;
    mm_pkg::t_dims            w_dims;

    logic                     w_f_valid, w_f_ready;
    mm_pkg::t_op              w_f_op;
    logic [ADDR_W-1:0]        w_f_addr;
    logic [ELEMENT_BITS-1:0]  w_f_data;
    logic [Q_W-1:0]           w_q_data;
    logic                     w_q_valid, w_q_ready;
    mm_pkg::t_result          w_out;

    function automatic logic [mm_pkg::CFG_W-1:0] eff_dim(input logic [mm_pkg::CFG_W-1:0] v);
        logic [mm_pkg::CFG_W-1:0] res;
        if (v == '0)               res = mm_pkg::CFG_W'(1);
        else if (int'(v) > MAX_DIM) res = mm_pkg::CFG_W'(MAX_DIM);
        else                       res = v;
        return res;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_rows  <= mm_pkg::CFG_RESET;
            r_left_cols  <= mm_pkg::CFG_RESET;
            r_right_rows <= mm_pkg::CFG_RESET;
            r_right_cols <= mm_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (mm_pkg::t_cfg_idx'(i_cfg_index))
                mm_pkg::CFG_LEFT_ROWS:  r_left_rows  <= i_cfg_data;
                mm_pkg::CFG_LEFT_COLS:  r_left_cols  <= i_cfg_data;
                mm_pkg::CFG_RIGHT_ROWS: r_right_rows <= i_cfg_data;
                mm_pkg::CFG_RIGHT_COLS: r_right_cols <= i_cfg_data;
            endcase
        end
    end

    assign w_dims.left_rows  = eff_dim(r_left_rows);
    assign w_dims.left_cols  = eff_dim(r_left_cols);
    assign w_dims.right_rows = eff_dim(r_right_rows);
    assign w_dims.right_cols = eff_dim(r_right_cols);

    mm_front #(
        .MAX_DIM      (MAX_DIM),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dims     (w_dims),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (s_axis_tuser),
        .i_element  (s_axis_tdata[ELEMENT_BITS-1:0]),
        .o_op_valid (w_f_valid),
        .i_op_ready (w_f_ready),
        .o_op       (w_f_op),
        .o_op_addr  (w_f_addr),
        .o_op_data  (w_f_data)
    );

    mm_queue #(
        .WIDTH (Q_W),
        .DEPTH (mm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  ({w_f_op, w_f_addr, w_f_data}),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_data)
    );

    mm_back #(
        .MAX_DIM      (MAX_DIM),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (w_dims),
        .i_op_valid  (w_q_valid),
        .o_op_ready  (w_q_ready),
        .i_op        (mm_pkg::t_op'(w_q_data[Q_W-1 -: 2])),
        .i_op_addr   (w_q_data[ELEMENT_BITS +: ADDR_W]),
        .i_op_data   (w_q_data[ELEMENT_BITS-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_out)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, w_out.col, w_out.row, w_out.product};
    assign m_axis_tlast = w_out.last;
    assign m_axis_tuser = w_out.error;

endmodule

// File: design/mm_front.sv
// Front end: accepts requests, tracks load pointers, classifies into operations.
module mm_front #(
    parameter int MAX_DIM      = 8,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mm_pkg::t_dims                        i_dims,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [mm_pkg::CMD_W-1:0]             i_cmd,
    input  logic [ELEMENT_BITS-1:0]              i_element,
    output logic                                 o_op_valid,
    input  logic                                 i_op_ready,
    output mm_pkg::t_op                          o_op,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   o_op_addr,
    output logic [ELEMENT_BITS-1:0]              o_op_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = (FILL_W > mm_pkg::SIZE_W) ? FILL_W : mm_pkg::SIZE_W;

    logic [FILL_W-1:0]         r_left_fill, n_left_fill;
    logic [FILL_W-1:0]         r_right_fill, n_right_fill;
    logic [mm_pkg::SIZE_W-1:0] w_left_size, w_right_size;
    logic                      w_left_room, w_right_room;
    logic                      w_accept;

    assign w_left_size  = mm_pkg::SIZE_W'(i_dims.left_rows) * mm_pkg::SIZE_W'(i_dims.left_cols);
    assign w_right_size = mm_pkg::SIZE_W'(i_dims.right_rows)
                        * mm_pkg::SIZE_W'(i_dims.right_cols);
    assign w_left_room  = CMP_W'(r_left_fill) < CMP_W'(w_left_size);
    assign w_right_room = CMP_W'(r_right_fill) < CMP_W'(w_right_size);

    assign o_ready   = i_op_ready;
    assign w_accept  = i_valid && i_op_ready;
    assign o_op_data = i_element;

    // Loads past the matrix size and the unused command are accepted and dropped.
    always_comb begin
        n_left_fill  = r_left_fill;
        n_right_fill = r_right_fill;
        o_op_valid   = 1'b0;
        o_op         = mm_pkg::OP_WR_LEFT;
        o_op_addr    = ADDR_W'(r_left_fill);
        unique case (mm_pkg::t_cmd'(i_cmd))
            mm_pkg::CMD_LOAD_LEFT: begin
                if (w_left_room) begin
                    o_op_valid  = i_valid;
                    n_left_fill = r_left_fill + FILL_W'(1);
                end
            end
            mm_pkg::CMD_LOAD_RIGHT: begin
                o_op      = mm_pkg::OP_WR_RIGHT;
                o_op_addr = ADDR_W'(r_right_fill);
                if (w_right_room) begin
                    o_op_valid   = i_valid;
                    n_right_fill = r_right_fill + FILL_W'(1);
                end
            end
            mm_pkg::CMD_COMPUTE: begin
                o_op_valid   = i_valid;
                o_op         = (i_dims.left_cols == i_dims.right_rows) ?
                               mm_pkg::OP_COMPUTE : mm_pkg::OP_MISMATCH;
                n_left_fill  = '0;
                n_right_fill = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_fill  <= '0;
            r_right_fill <= '0;
        end else if (w_accept) begin
            r_left_fill  <= n_left_fill;
            r_right_fill <= n_right_fill;
        end
    end

endmodule

// File: design/mm_queue.sv
// Small FIFO between the front end and the back end.
module mm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (w_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            r_count <= r_count + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// File: design/mm_back.sv
// Back end: element stores and the multiply-accumulate pipeline.
module mm_back #(
    parameter int MAX_DIM      = 8,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mm_pkg::t_dims                        i_dims,
    input  logic                                 i_op_valid,
    output logic                                 o_op_ready,
    input  mm_pkg::t_op                          i_op,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   i_op_addr,
    input  logic [ELEMENT_BITS-1:0]              i_op_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output mm_pkg::t_result                      o_out
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int PROD_W = 2 * ELEMENT_BITS;
    localparam int EXT_W  = ((PROD_W > mm_pkg::PRODUCT_W) ? PROD_W : mm_pkg::PRODUCT_W) + 1;
    localparam int SUM_W  = mm_pkg::PRODUCT_W + 1;

    localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'({1'b0, {(mm_pkg::PRODUCT_W-1){1'b1}}});
    localparam logic signed [EXT_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'(SAT_MAX);
    localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

    typedef enum logic {S_IDLE, S_COMPUTE} t_state;

    // Stores; an entry without its valid bit reads as zero.
    logic [ELEMENT_BITS-1:0] r_left_mem  [DEPTH];
    logic [ELEMENT_BITS-1:0] r_right_mem [DEPTH];
    logic [DEPTH-1:0]        r_left_vld, r_right_vld;

    t_state            r_state;
    logic [CNT_W-1:0]  r_row, r_col, r_k;
    logic [ADDR_W-1:0] r_row_base, r_la, r_ra;

    // Stage 1: read data; stage 2: product; then accumulate
    logic                    r_s1_valid, r_s1_first, r_s1_last, r_s1_final;
    logic [CNT_W-1:0]        r_s1_row, r_s1_col;
    logic [ELEMENT_BITS-1:0] r_l_data, r_r_data;
    logic                    r_l_ok, r_r_ok;
    logic                    r_s2_valid, r_s2_first, r_s2_last, r_s2_final;
    logic [CNT_W-1:0]        r_s2_row, r_s2_col;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [mm_pkg::PRODUCT_W-1:0] r_acc;

    logic                    r_out_valid;
    mm_pkg::t_result         r_out;

    logic signed [ELEMENT_BITS-1:0]      w_l, w_r;
    logic signed [EXT_W-1:0]             w_prod_ext;
    logic signed [mm_pkg::PRODUCT_W-1:0] w_term, w_base, w_acc_next;
    logic signed [SUM_W-1:0]             w_sum;
    logic w_pop, w_issue, w_stall, w_out_free, w_pipe_empty;
    logic w_k_last, w_col_last, w_row_last;

    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_pipe_empty = !r_s1_valid && !r_s2_valid;
    assign w_stall      = r_s2_valid && r_s2_last && !w_out_free;
    assign w_issue      = (r_state == S_COMPUTE) && !w_stall;

    assign w_k_last   = (mm_pkg::CFG_W'(r_k) + mm_pkg::CFG_W'(1)) == i_dims.left_cols;
    assign w_col_last = (mm_pkg::CFG_W'(r_col) + mm_pkg::CFG_W'(1)) == i_dims.right_cols;
    assign w_row_last = (mm_pkg::CFG_W'(r_row) + mm_pkg::CFG_W'(1)) == i_dims.left_rows;

    // An error result must follow every product of an earlier compute.
    always_comb begin
        o_op_ready = 1'b0;
        if (r_state == S_IDLE && i_op_valid) begin
            unique case (i_op)
                mm_pkg::OP_WR_LEFT, mm_pkg::OP_WR_RIGHT, mm_pkg::OP_COMPUTE:
                    o_op_ready = 1'b1;
                mm_pkg::OP_MISMATCH:
                    o_op_ready = w_pipe_empty && w_out_free;
            endcase
        end
    end
    assign w_pop = i_op_valid && o_op_ready;

    assign w_l        = r_l_ok ? r_l_data : '0;
    assign w_r        = r_r_ok ? r_r_data : '0;
    assign w_prod_ext = EXT_W'(r_prod);

    always_comb begin
        if (w_prod_ext > SAT_MAX)      w_term = SAT_MAX[mm_pkg::PRODUCT_W-1:0];
        else if (w_prod_ext < SAT_MIN) w_term = SAT_MIN[mm_pkg::PRODUCT_W-1:0];
        else                           w_term = w_prod_ext[mm_pkg::PRODUCT_W-1:0];
        w_base = r_s2_first ? '0 : r_acc;
        w_sum  = SUM_W'(w_term) + SUM_W'(w_base);
        if (w_sum > ACC_MAX)      w_acc_next = ACC_MAX[mm_pkg::PRODUCT_W-1:0];
        else if (w_sum < ACC_MIN) w_acc_next = ACC_MIN[mm_pkg::PRODUCT_W-1:0];
        else                      w_acc_next = w_sum[mm_pkg::PRODUCT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // address walk: left steps by one, right steps by a row
            if (w_pop && i_op == mm_pkg::OP_COMPUTE) begin
                r_state    <= S_COMPUTE;
                r_row      <= '0;
                r_col      <= '0;
                r_k        <= '0;
                r_row_base <= '0;
                r_la       <= '0;
                r_ra       <= '0;
            end else if (w_issue) begin
                if (!w_k_last) begin
                    r_k  <= r_k + CNT_W'(1);
                    r_la <= r_la + ADDR_W'(1);
                    r_ra <= r_ra + ADDR_W'(i_dims.right_cols);
                end else if (!w_col_last) begin
                    r_k   <= '0;
                    r_col <= r_col + CNT_W'(1);
                    r_la  <= r_row_base;
                    r_ra  <= ADDR_W'(r_col) + ADDR_W'(1);
                end else if (!w_row_last) begin
                    r_k        <= '0;
                    r_col      <= '0;
                    r_row      <= r_row + CNT_W'(1);
                    r_row_base <= r_row_base + ADDR_W'(i_dims.left_cols);
                    r_la       <= r_row_base + ADDR_W'(i_dims.left_cols);
                    r_ra       <= '0;
                end else begin
                    r_state <= S_IDLE;
                end
            end

            if (!w_stall) begin
                r_s1_valid <= w_issue;
                r_s1_first <= r_k == '0;
                r_s1_last  <= w_k_last;
                r_s1_final <= w_k_last && w_col_last && w_row_last;
                r_s1_row   <= r_row;
                r_s1_col   <= r_col;
                r_s2_valid <= r_s1_valid;
                r_s2_first <= r_s1_first;
                r_s2_last  <= r_s1_last;
                r_s2_final <= r_s1_final;
                r_s2_row   <= r_s1_row;
                r_s2_col   <= r_s1_col;
            end

            if (w_pop && i_op == mm_pkg::OP_MISMATCH) begin
                r_out_valid <= 1'b1;
                r_out       <= '{product: '0, row: '0, col: '0, last: 1'b1, error: 1'b1};
            end else if (r_s2_valid && r_s2_last && !w_stall) begin
                r_out_valid   <= 1'b1;
                r_out.product <= w_acc_next;
                r_out.row     <= mm_pkg::IDX_W'(r_s2_row);
                r_out.col     <= mm_pkg::IDX_W'(r_s2_col);
                r_out.last    <= r_s2_final;
                r_out.error   <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_vld  <= '0;
            r_right_vld <= '0;
        end else if (w_pop) begin
            if (i_op == mm_pkg::OP_WR_LEFT)  r_left_vld[i_op_addr]  <= 1'b1;
            if (i_op == mm_pkg::OP_WR_RIGHT) r_right_vld[i_op_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_op == mm_pkg::OP_WR_LEFT)  r_left_mem[i_op_addr]  <= i_op_data;
        if (w_pop && i_op == mm_pkg::OP_WR_RIGHT) r_right_mem[i_op_addr] <= i_op_data;
        if (w_issue) begin
            r_l_data <= r_left_mem[r_la];
            r_r_data <= r_right_mem[r_ra];
            r_l_ok   <= r_left_vld[r_la];
            r_r_ok   <= r_right_vld[r_ra];
        end
        if (!w_stall && r_s1_valid) r_prod <= w_l * w_r;
        if (!w_stall && r_s2_valid && !r_s2_last) r_acc <= w_acc_next;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_error_is_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.error |-> r_out.last && r_out.product == '0)
        else $error("error result without last or with a product");

    a_left_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMPUTE |-> r_la == r_row_base + ADDR_W'(r_k))
        else $error("left address out of step with row and column counters");

    a_right_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMPUTE |->
            r_ra == ADDR_W'(ADDR_W'(r_k) * ADDR_W'(i_dims.right_cols) + ADDR_W'(r_col)))
        else $error("right address out of step with counters");

    a_final_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_final |-> r_s2_last)
        else $error("final marker on a partial sum");
`endif

endmodule
